>>> hw/rtl/spmq_pkg.sv
// Shared types, field widths and codes for the strict-priority queue.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps

package spmq_pkg;

    // Default configuration handed to the top level parameters
    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_LEVELS      = 3;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed widths of the transfer fields
    localparam int VALUE_FIELD_W = 32;
    localparam int PRIO_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;
    localparam int TOTAL_FIELD_W = 6;
    localparam int SHOWN_LEVELS  = 3;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO = 2'd3;

    typedef struct packed {
        logic                            command;
        logic signed [VALUE_FIELD_W-1:0] item_value;
        logic [PRIO_W-1:0]               item_priority;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]             status;
        logic signed [VALUE_FIELD_W-1:0] popped_value;
        logic [PRIO_W-1:0]               popped_priority;
        logic signed [VALUE_FIELD_W-1:0] head_value;
        logic [PRIO_W-1:0]               head_priority;
        logic                            queue_empty;
        logic [TOTAL_FIELD_W-1:0]        total_count;
        logic [COUNT_FIELD_W-1:0]        low_count;
        logic [COUNT_FIELD_W-1:0]        medium_count;
        logic [COUNT_FIELD_W-1:0]        high_count;
    } result_t;

    // Classified operation passed from front to back
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_POP,
        OP_BAD_PRIO
    } op_kind_t;

    typedef struct packed {
        op_kind_t                        kind;
        logic [PRIO_W-1:0]               level;
        logic signed [VALUE_FIELD_W-1:0] value;
    } op_t;

endpackage

>>> hw/rtl/spmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/spmq_front.sv
// Front end: takes command transfers, classifies them and queues them for the back end.
// Depends on spmq_pkg.
`timescale 1ns / 1ps

module spmq_front
    import spmq_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     op_valid,
    output op_t      op,
    input  logic     op_take
);

    op_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push;
    op_t               op_in;

    // Classify the incoming command
    always_comb
    begin
        op_in.level = request.item_priority;
        op_in.value = request.item_value;
        if (request.command == CMD_POP)
        begin
            op_in.kind = OP_POP;
        end
        else if (32'(request.item_priority) >= 32'(LEVELS))
        begin
            op_in.kind = OP_BAD_PRIO;
        end
        else
        begin
            op_in.kind = OP_INSERT;
        end
    end

    assign busy     = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = start && !busy;
    assign op_valid = (fill_reg != '0);
    assign op       = q_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (op_take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !op_take)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && op_take)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued operations
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

>>> hw/rtl/spmq_back.sv
// Back end: carries out queued operations on the per-level FIFOs and builds each result.
// Depends on spmq_pkg; drives the entry RAM instanced at the top level.
`timescale 1ns / 1ps

module spmq_back
    import spmq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int LEVELS      = DEF_LEVELS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   op_valid,
    input  op_t                                    op,
    output logic                                   op_take,
    output logic                                   ram_we,
    output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]  ram_waddr,
    output logic [VALUE_WIDTH-1:0]                 ram_wdata,
    output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]  ram_raddr,
    input  logic [VALUE_WIDTH-1:0]                 ram_rdata,
    output logic                                   done,
    output result_t                                result
);

    localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_HEAD
    } state_t;

    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic                       pop_ok_reg, pop_ok_next;
    logic [LVL_W-1:0]           pop_lvl_reg, pop_lvl_next;
    logic [VALUE_FIELD_W-1:0]   popped_reg, popped_next;
    logic                       done_reg, done_next;
    result_t                    result_reg, result_next;

    logic [PTR_W-1:0]           rp_reg [LEVELS];
    logic [PTR_W-1:0]           rp_next [LEVELS];
    logic [PTR_W-1:0]           wp_reg [LEVELS];
    logic [PTR_W-1:0]           wp_next [LEVELS];
    logic [CNT_W-1:0]           cnt_reg [LEVELS];
    logic [CNT_W-1:0]           cnt_next [LEVELS];
    logic [TOT_W-1:0]           total_reg, total_next;

    logic                       any_entry;
    logic [LVL_W-1:0]           top_lvl;
    logic [LVL_W-1:0]           op_lvl;
    logic                       lvl_full;
    logic                       do_insert;
    logic                       do_pop;
    logic [COUNT_FIELD_W-1:0]   shown [SHOWN_LEVELS];

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
        return ADDR_W'(32'(lvl) * LEVEL_DEPTH) + ADDR_W'(ptr);
    endfunction

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Find the highest non-empty level
    always_comb
    begin
        any_entry = 1'b0;
        top_lvl   = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (cnt_reg[l] != '0)
            begin
                any_entry = 1'b1;
                top_lvl   = LVL_W'(l);
            end
        end
    end

    assign op_lvl    = LVL_W'(op_reg.level);
    assign lvl_full  = (cnt_reg[op_lvl] == CNT_W'(LEVEL_DEPTH));
    assign do_insert = (state_reg == S_EXEC) && (op_reg.kind == OP_INSERT) && !lvl_full;
    assign do_pop    = (state_reg == S_EXEC) && (op_reg.kind == OP_POP) && any_entry;

    // Entry RAM: write on insert, always read the current head slot
    assign ram_we    = do_insert;
    assign ram_waddr = addr_of(op_lvl, wp_reg[op_lvl]);
    assign ram_wdata = VALUE_WIDTH'(op_reg.value);
    assign ram_raddr = addr_of(top_lvl, rp_reg[top_lvl]);

    // Update level pointers and counts
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        if (do_insert)
        begin
            wp_next[op_lvl]  = advance(wp_reg[op_lvl]);
            cnt_next[op_lvl] = cnt_reg[op_lvl] + 1'b1;
            total_next       = total_reg + 1'b1;
        end
        if (do_pop)
        begin
            rp_next[top_lvl]  = advance(rp_reg[top_lvl]);
            cnt_next[top_lvl] = cnt_reg[top_lvl] - 1'b1;
            total_next        = total_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                rp_reg[l]  <= '0;
                wp_reg[l]  <= '0;
                cnt_reg[l] <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
        end
    end

    // Per-level counts as reported; missing levels read zero
    always_comb
    begin
        for (int k = 0; k < SHOWN_LEVELS; k++)
        begin
            shown[k] = '0;
        end
        for (int l = 0; l < LEVELS && l < SHOWN_LEVELS; l++)
        begin
            shown[l] = COUNT_FIELD_W'(cnt_reg[l]);
        end
    end

    // Sequence each operation: execute, collect popped value, collect head
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        pop_ok_next  = pop_ok_reg;
        pop_lvl_next = pop_lvl_reg;
        popped_next  = popped_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        op_take      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_take    = 1'b1;
                    op_next    = op;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pop_ok_next  = do_pop;
                pop_lvl_next = top_lvl;
                unique case (op_reg.kind)
                    OP_BAD_PRIO: status_next = ST_BAD_PRIO;
                    OP_INSERT:   status_next = lvl_full ? ST_FULL : ST_OK;
                    OP_POP:      status_next = any_entry ? ST_OK : ST_EMPTY;
                    default:     status_next = ST_OK;
                endcase
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                popped_next = pop_ok_reg ? VALUE_FIELD_W'(ram_rdata) : '0;
                state_next  = S_HEAD;
            end
            S_HEAD:
            begin
                result_next.status          = status_reg;
                result_next.popped_value    = popped_reg;
                result_next.popped_priority = pop_ok_reg ? PRIO_W'(pop_lvl_reg) : '0;
                result_next.head_value      = any_entry ? VALUE_FIELD_W'(ram_rdata) : '0;
                result_next.head_priority   = any_entry ? PRIO_W'(top_lvl) : '0;
                result_next.queue_empty     = !any_entry;
                result_next.total_count     = TOTAL_FIELD_W'(total_reg);
                result_next.low_count       = shown[0];
                result_next.medium_count    = shown[1];
                result_next.high_count      = shown[2];
                done_next                   = 1'b1;
                if (op_valid)
                begin
                    op_take    = 1'b1;
                    op_next    = op;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= '0;
            status_reg  <= ST_OK;
            pop_ok_reg  <= 1'b0;
            pop_lvl_reg <= '0;
            popped_reg  <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            status_reg  <= status_next;
            pop_ok_reg  <= pop_ok_next;
            pop_lvl_reg <= pop_lvl_next;
            popped_reg  <= popped_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/strict_priority_multilevel_queue_unit.sv
// Top level of the strict-priority multilevel queue: front end, command queue, back end, RAM.
// Depends on spmq_pkg, spmq_ram, spmq_front and spmq_back.
//
//  channel   signals                  transfer when
//  command   start, busy, request     start high and busy low at the clock edge
//  result    done, result             done high; one cycle, receiver cannot stall
//
// In the back end a command goes through execute, fetch popped entry and fetch head, in that
// order, since the entry RAM has a single read port; done is registered after the fetch
// head step. A two-entry command queue takes further commands meanwhile; busy is high
// while it is full. Reset clears all levels at once; RAM contents are never read unwritten.
`timescale 1ns / 1ps

module strict_priority_multilevel_queue_unit
    import spmq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int LEVELS      = DEF_LEVELS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic                   op_valid;
    op_t                    op;
    logic                   op_take;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    spmq_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    spmq_back #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .LEVELS      (LEVELS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .done      (done),
        .result    (result)
    );

    spmq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
